// ===== rtl/ch_hist_pkg.sv =====
// ----------------------------------------------------------------------------
// ch_hist_pkg
// Types and constants shared by the channel histogram modules.
// ----------------------------------------------------------------------------
package ch_hist_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_WIDTH   = $clog2(NUM_BINS);
  localparam int COUNT_WIDTH = 32;
  localparam int CHAN_WIDTH  = 8;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_NUM_CHANNELS   = 1'b0;
  localparam logic REG_CHANNEL_SELECT = 1'b1;

  localparam logic [2:0] NUM_CHANNELS_RESET   = 3'd3;
  localparam logic [1:0] CHANNEL_SELECT_RESET = 2'd0;

  typedef struct packed {
    logic [1:0]            command;
    logic [CHAN_WIDTH-1:0] chan_0;
    logic [CHAN_WIDTH-1:0] chan_1;
    logic [CHAN_WIDTH-1:0] chan_2;
    logic [CHAN_WIDTH-1:0] chan_3;
    logic [BIN_WIDTH-1:0]  bin_index;
  } in_word_t;

  typedef struct packed {
    logic [BIN_WIDTH-1:0]   read_bin;
    logic [COUNT_WIDTH-1:0] bin_count;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic write;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic present;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/channel_histogram.sv =====
// ----------------------------------------------------------------------------
// channel_histogram
// 256-bin saturating histogram of one selected channel of a pixel stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in        in   in_valid / in_ready    in_word_t  (command, chan_0..3, bin)
//  out       out  out_valid / out_ready  out_word_t (read_bin, bin_count)
//  config    in   write_en               write_index, write_data
//
//  Clear and ignored adds end on acceptance; a counted add steps through
//  accept, memory fetch and update, a read through accept, fetch and a
//  respond step held by output stall. Reset and clear zero all bins at
//  once through per-bin valid flags. A finished read waits in the output
//  register while new words are taken.
module channel_histogram (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_en,
  input  logic                   write_index,
  input  logic [2:0]             write_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ch_hist_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ch_hist_pkg::out_word_t out_data
);

  ch_hist_pkg::dp_cmd_t    cmd;
  ch_hist_pkg::dp_status_t status;

  ch_hist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (in_data.command),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ch_hist_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/ch_hist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ch_hist_ctrl
// Sequencer: accepts a word, steps the bin memory through fetch and update
// or fetch and respond.
// ----------------------------------------------------------------------------
module ch_hist_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             command,
  output logic                   in_ready,
  input  ch_hist_pkg::dp_status_t status,
  output ch_hist_pkg::dp_cmd_t    cmd
);

  ch_hist_pkg::state_t state, state_next;
  logic is_read, is_read_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ch_hist_pkg::ST_IDLE;
      is_read <= 1'b0;
    end else begin
      state   <= state_next;
      is_read <= is_read_next;
    end
  end

  always_comb begin
    state_next   = state;
    is_read_next = is_read;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      ch_hist_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == ch_hist_pkg::CMD_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (command == ch_hist_pkg::CMD_READ) begin
            cmd.capture  = 1'b1;
            is_read_next = 1'b1;
            state_next   = ch_hist_pkg::ST_FETCH;
          end else if (command == ch_hist_pkg::CMD_ADD && status.present) begin
            cmd.capture  = 1'b1;
            is_read_next = 1'b0;
            state_next   = ch_hist_pkg::ST_FETCH;
          end
        end
      end
      ch_hist_pkg::ST_FETCH: begin
        state_next = is_read ? ch_hist_pkg::ST_RESPOND : ch_hist_pkg::ST_UPDATE;
      end
      ch_hist_pkg::ST_UPDATE: begin
        cmd.write  = 1'b1;
        state_next = ch_hist_pkg::ST_IDLE;
      end
      ch_hist_pkg::ST_RESPOND: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ch_hist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ch_hist_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ch_hist_dp.sv =====
// ----------------------------------------------------------------------------
// ch_hist_dp
// Datapath: config registers, bin memory with per-bin valid flags,
// saturating increment and output register.
// ----------------------------------------------------------------------------
module ch_hist_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write_en,
  input  logic                    write_index,
  input  logic [2:0]              write_data,
  input  ch_hist_pkg::in_word_t   in_data,
  input  ch_hist_pkg::dp_cmd_t    cmd,
  output ch_hist_pkg::dp_status_t status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ch_hist_pkg::out_word_t  out_data
);

  logic [2:0] num_channels;
  logic [1:0] channel_select;
  logic [ch_hist_pkg::CHAN_WIDTH-1:0]  chan_sel;
  logic [ch_hist_pkg::BIN_WIDTH-1:0]   addr;
  logic [ch_hist_pkg::NUM_BINS-1:0]    bin_valid;
  logic [ch_hist_pkg::COUNT_WIDTH-1:0] mem [ch_hist_pkg::NUM_BINS];
  logic [ch_hist_pkg::COUNT_WIDTH-1:0] rdata;
  logic [ch_hist_pkg::COUNT_WIDTH-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels   <= ch_hist_pkg::NUM_CHANNELS_RESET;
      channel_select <= ch_hist_pkg::CHANNEL_SELECT_RESET;
    end else if (write_en) begin
      if (write_index == ch_hist_pkg::REG_NUM_CHANNELS) begin
        num_channels <= write_data;
      end else begin
        channel_select <= write_data[1:0];
      end
    end
  end

  always_comb begin
    case (channel_select)
      2'd0:    chan_sel = in_data.chan_0;
      2'd1:    chan_sel = in_data.chan_1;
      2'd2:    chan_sel = in_data.chan_2;
      default: chan_sel = in_data.chan_3;
    endcase
  end

  assign status.present  = {1'b0, channel_select} < num_channels;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr <= (in_data.command == ch_hist_pkg::CMD_READ) ? in_data.bin_index : chan_sel;
    end
  end

  // unwritten bins read as zero
  assign count = bin_valid[addr] ? rdata : '0;

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (cmd.write && count != '1) begin
      mem[addr] <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      bin_valid <= '0;
    end else if (cmd.write) begin
      bin_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.read_bin  <= addr;
      out_data.bin_count <= count;
    end
  end

endmodule

// ===== rtl/ch_hist_checker.sv =====
// ----------------------------------------------------------------------------
// ch_hist_checker
// Port-level checks for channel_histogram.
// ----------------------------------------------------------------------------
module ch_hist_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input ch_hist_pkg::in_word_t  in_data,
  input logic                   out_valid,
  input logic                   out_ready,
  input ch_hist_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out word changed while stalled");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.command == ch_hist_pkg::CMD_READ |=> !in_ready)
    else $error("read accepted without going busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out valid after reset");

endmodule

bind channel_histogram ch_hist_checker u_ch_hist_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/channel_histogram_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_histogram_tb
// Drives clear, add, read and unused words into the histogram with random
// gaps on both channels, keeps a bin-by-bin model of the counts, and checks
// every read word against it across a sweep of channel count and select.
// ----------------------------------------------------------------------------
module channel_histogram_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_WORDS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic write_index = 1'b0;
  logic [2:0] write_data = 3'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  ch_hist_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ch_hist_pkg::out_word_t out_data;

  ch_hist_pkg::in_word_t pending_words[$];
  ch_hist_pkg::out_word_t expected_reads[$];
  logic [ch_hist_pkg::COUNT_WIDTH-1:0] hist_model[ch_hist_pkg::NUM_BINS];
  logic [2:0] nc_model = ch_hist_pkg::NUM_CHANNELS_RESET;
  logic [1:0] sel_model = ch_hist_pkg::CHANNEL_SELECT_RESET;
  logic [7:0] hot_vals[4];
  logic in_taken = 1'b0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_pushed = 0;
  int words_accepted = 0;
  int pixels_counted = 0;
  int reads_checked = 0;
  int mismatches = 0;
  int settings_used = 1;

  channel_histogram DUT (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .write_index(write_index),
    .write_data (write_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] counted_channel(input ch_hist_pkg::in_word_t w);
    case (sel_model)
      2'd0: return w.chan_0;
      2'd1: return w.chan_1;
      2'd2: return w.chan_2;
      default: return w.chan_3;
    endcase
  endfunction

  task automatic update_histogram(input ch_hist_pkg::in_word_t w);
    logic [7:0] v;
    ch_hist_pkg::out_word_t r;
    case (w.command)
      ch_hist_pkg::CMD_CLEAR: begin
        foreach (hist_model[i]) hist_model[i] = '0;
      end
      ch_hist_pkg::CMD_ADD: begin
        if ({1'b0, sel_model} < nc_model) begin
          v = counted_channel(w);
          if (hist_model[v] != '1) hist_model[v] = hist_model[v] + 1'b1;
          pixels_counted++;
        end
      end
      ch_hist_pkg::CMD_READ: begin
        r.read_bin = w.bin_index;
        r.bin_count = hist_model[w.bin_index];
        expected_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_miss(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  task automatic check_read(input ch_hist_pkg::out_word_t got);
    ch_hist_pkg::out_word_t want;
    if (expected_reads.size() == 0) begin
      report_miss("unexpected read word (bin)", 32'hx, 32'(got.read_bin));
    end else begin
      want = expected_reads.pop_front();
      reads_checked++;
      if (got.read_bin !== want.read_bin)
        report_miss("read_bin", 32'(want.read_bin), 32'(got.read_bin));
      if (got.bin_count !== want.bin_count)
        report_miss("bin_count", want.bin_count, got.bin_count);
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: sample on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        words_accepted++;
        update_histogram(in_data);
      end
      if (out_valid && out_ready) check_read(out_data);
    end
  end

  task automatic queue_word(input logic [1:0] cmd, input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] b);
    ch_hist_pkg::in_word_t w;
    w.command = cmd;
    w.chan_0 = c0;
    w.chan_1 = c1;
    w.chan_2 = c2;
    w.chan_3 = c3;
    w.bin_index = b;
    pending_words.push_back(w);
    words_pushed++;
  endtask

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return hot_vals[2'($urandom_range(3))];
    if (r < 9) return 8'($urandom_range(255));
    return $urandom_range(1) ? 8'hff : 8'h00;
  endfunction

  function automatic ch_hist_pkg::in_word_t random_word();
    ch_hist_pkg::in_word_t w;
    int r;
    r = $urandom_range(99);
    w.chan_0 = pick_value();
    w.chan_1 = pick_value();
    w.chan_2 = pick_value();
    w.chan_3 = pick_value();
    w.bin_index = pick_value();
    if (r < 3) w.command = ch_hist_pkg::CMD_CLEAR;
    else if (r < 62) w.command = ch_hist_pkg::CMD_ADD;
    else if (r < 94) w.command = ch_hist_pkg::CMD_READ;
    else w.command = CMD_UNUSED;
    return w;
  endfunction

  // called on a falling edge with the block idle
  task automatic write_config(input logic [2:0] nc, input logic [2:0] sel_data);
    write_en <= 1'b1;
    write_index <= ch_hist_pkg::REG_NUM_CHANNELS;
    write_data <= nc;
    nc_model = nc;
    @(negedge clk);
    write_index <= ch_hist_pkg::REG_CHANNEL_SELECT;
    write_data <= sel_data;
    sel_model = sel_data[1:0];
    @(negedge clk);
    write_en <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (words_accepted != words_pushed || expected_reads.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  logic [2:0] phase_nc[8] = '{3'd4, 3'd1, 3'd3, 3'd2, 3'd0, 3'd7, 3'd5, 3'd4};
  logic [1:0] phase_sel[8] = '{2'd3, 2'd0, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1, 2'd1};
  int idle_pct[4] = '{0, 73, 0, 20};
  int stall_pct[4] = '{0, 0, 73, 20};

  initial begin
    foreach (hist_model[i]) hist_model[i] = '0;
    foreach (hot_vals[i]) hot_vals[i] = 8'($urandom_range(255));
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset values of the registers: three channels, channel 0 counted
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_word(ch_hist_pkg::CMD_READ,  8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_word(ch_hist_pkg::CMD_ADD,   8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_word(ch_hist_pkg::CMD_ADD,   8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_word(ch_hist_pkg::CMD_ADD,   8'hff, 8'h12, 8'h34, 8'h56, 8'h00);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
    queue_word(CMD_UNUSED,             8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
    queue_word(ch_hist_pkg::CMD_ADD,   8'h55, 8'haa, 8'haa, 8'haa, 8'h55);
    queue_word(ch_hist_pkg::CMD_ADD,   8'h55, 8'h00, 8'h00, 8'h00, 8'haa);
    queue_word(ch_hist_pkg::CMD_READ,  8'hff, 8'hff, 8'hff, 8'hff, 8'h55);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'haa);
    queue_word(ch_hist_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
    queue_word(ch_hist_pkg::CMD_ADD,   8'haa, 8'h55, 8'h55, 8'h55, 8'h00);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'haa);
    queue_word(ch_hist_pkg::CMD_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'haa);
    queue_word(ch_hist_pkg::CMD_READ,  8'h00, 8'h00, 8'h00, 8'h00, 8'h55);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      sender_idle_pct = idle_pct[p % 4];
      recv_stall_pct = stall_pct[p % 4];
      write_config(phase_nc[p], {1'($urandom_range(1)), phase_sel[p]});
      foreach (hot_vals[i]) hot_vals[i] = 8'($urandom_range(255));
      queue_word(ch_hist_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      repeat (PHASE_WORDS) begin
        pending_words.push_back(random_word());
        words_pushed++;
      end
      wait_idle();
    end

    if (expected_reads.size() != 0)
      report_miss("reads never returned (count)", 32'd0, 32'(expected_reads.size()));
    $display("Ran %0d words over %0d register settings: %0d pixels counted, %0d reads checked",
             words_accepted, settings_used, pixels_counted, reads_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ch_hist_pkg.sv
rtl/ch_hist_ctrl.sv
rtl/ch_hist_dp.sv
rtl/channel_histogram.sv
rtl/ch_hist_checker.sv
tb/sv/channel_histogram_tb.sv
